// ----- hdl/bfha_pkg.sv -----
// Shared types, constants and a helper function of the best-fit heap allocator.
package bfha_pkg;

  localparam int HEAP_BYTES   = 1024;
  localparam int HEADER_BYTES = 16;
  localparam int MAX_NODES    = HEAP_BYTES / HEADER_BYTES + 1;

  localparam int PTR_W  = 11;
  localparam int ADDR_W = $clog2(HEAP_BYTES);
  localparam int SUM_W  = 13;
  localparam int STEP_W = $clog2(MAX_NODES + 1);

  localparam logic [PTR_W-1:0]  NULL_PTR  = PTR_W'(HEAP_BYTES);
  localparam logic [PTR_W-1:0]  HDR_P     = PTR_W'(HEADER_BYTES);
  localparam logic [SUM_W-1:0]  HDR_S     = SUM_W'(HEADER_BYTES);
  localparam logic [PTR_W-1:0]  INIT_SIZE = PTR_W'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [STEP_W-1:0] MAX_STEPS = STEP_W'(MAX_NODES);

  typedef enum logic [1:0] {
    ST_ALLOC = 2'd0,
    ST_NOMEM = 2'd1,
    ST_FREED = 2'd2,
    ST_NULL  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_A_WALK,
    S_A_W1,
    S_A_W2,
    S_A_W3,
    S_F_WALK,
    S_F_BLK,
    S_F_W1,
    S_F_W2,
    S_EMIT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_DECODE,
    OP_A_START,
    OP_A_STEP,
    OP_A_W1,
    OP_A_W2,
    OP_A_W3,
    OP_F_START,
    OP_F_STEP,
    OP_F_BLKRD,
    OP_F_W1,
    OP_F_W2,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   in_ready;
  } dp_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic is_null;
    logic bad_off;
    logic head_ok;
    logic a_more;
    logic f_stay;
    logic best_ok;
    logic out_free;
  } dp_status_t;

  function automatic logic link_ok(input logic [PTR_W-1:0] p);
    return p < NULL_PTR;
  endfunction

endpackage

// ----- hdl/best_fit_heap_allocator_core.sv -----
// Best-fit heap allocator: one item per transfer, one node of the free chain per cycle.
// An allocate walks the chain of N free blocks (N at most 65) and, if one fits, splits
// and relinks it; a free walks the K free blocks below it, then reads its own header and
// merges with adjacent free blocks; null or bad frees skip the walk. A held result stalls.
// Throughput: one item at a time, set by the single read port walking the header stores.
// Reset: synchronous, active low; first header written in S_INIT, then in_tready rises.
module best_fit_heap_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // request_size [10:0], free_offset [21:11], zero pad
  input  logic [1:0]  in_tuser,   // command [0], free_is_null [1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // data_offset [10:0], granted_size [21:11], zero pad
  output logic [1:0]  out_tuser   // status [1:0]
);

  bfha_pkg::dp_cmd_t    cmd;
  bfha_pkg::dp_status_t sts;

  bfha_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .sts(sts), .cmd(cmd)
  );

  bfha_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_tvalid(in_tvalid), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  assign in_tready = cmd.in_ready;

endmodule

// ----- hdl/bfha_ram.sv -----
// Generic simple dual-port RAM with registered read data.
module bfha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/bfha_ctrl.sv -----
// Controller state machine sequencing allocate and free walks.
module bfha_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  bfha_pkg::dp_status_t sts,
  output bfha_pkg::dp_cmd_t    cmd
);

  bfha_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfha_pkg::S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = bfha_pkg::OP_NONE;
    cmd.in_ready = 1'b0;
    case (state_r)
      bfha_pkg::S_INIT: begin
        cmd.op    = bfha_pkg::OP_INIT;
        state_nxt = bfha_pkg::S_IDLE;
      end
      bfha_pkg::S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_tvalid) begin
          state_nxt = bfha_pkg::S_DECODE;
        end
      end
      bfha_pkg::S_DECODE: begin
        if (sts.is_alloc) begin
          cmd.op    = bfha_pkg::OP_A_START;
          state_nxt = sts.head_ok ? bfha_pkg::S_A_WALK : bfha_pkg::S_A_W1;
        end else if (sts.is_null || sts.bad_off) begin
          cmd.op    = bfha_pkg::OP_DECODE;
          state_nxt = bfha_pkg::S_EMIT;
        end else begin
          cmd.op    = bfha_pkg::OP_F_START;
          state_nxt = sts.head_ok ? bfha_pkg::S_F_WALK : bfha_pkg::S_F_BLK;
        end
      end
      bfha_pkg::S_A_WALK: begin
        cmd.op = bfha_pkg::OP_A_STEP;
        if (!sts.a_more) begin
          state_nxt = bfha_pkg::S_A_W1;
        end
      end
      bfha_pkg::S_A_W1: begin
        cmd.op    = bfha_pkg::OP_A_W1;
        state_nxt = sts.best_ok ? bfha_pkg::S_A_W2 : bfha_pkg::S_EMIT;
      end
      bfha_pkg::S_A_W2: begin
        cmd.op    = bfha_pkg::OP_A_W2;
        state_nxt = bfha_pkg::S_A_W3;
      end
      bfha_pkg::S_A_W3: begin
        cmd.op    = bfha_pkg::OP_A_W3;
        state_nxt = bfha_pkg::S_EMIT;
      end
      bfha_pkg::S_F_WALK: begin
        cmd.op = bfha_pkg::OP_F_STEP;
        if (!sts.f_stay) begin
          state_nxt = bfha_pkg::S_F_BLK;
        end
      end
      bfha_pkg::S_F_BLK: begin
        cmd.op    = bfha_pkg::OP_F_BLKRD;
        state_nxt = bfha_pkg::S_F_W1;
      end
      bfha_pkg::S_F_W1: begin
        cmd.op    = bfha_pkg::OP_F_W1;
        state_nxt = bfha_pkg::S_F_W2;
      end
      bfha_pkg::S_F_W2: begin
        cmd.op    = bfha_pkg::OP_F_W2;
        state_nxt = bfha_pkg::S_EMIT;
      end
      bfha_pkg::S_EMIT: begin
        if (sts.out_free) begin
          cmd.op    = bfha_pkg::OP_EMIT;
          state_nxt = bfha_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bfha_pkg::S_INIT;
      end
    endcase
  end

endmodule

// ----- hdl/bfha_dp.sv -----
// Datapath: header stores, walk registers, merge arithmetic and output register.
module bfha_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  bfha_pkg::dp_cmd_t    cmd,
  output bfha_pkg::dp_status_t sts,
  input  logic                in_tvalid,
  input  logic [23:0]         in_tdata,
  input  logic [1:0]          in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [23:0]         out_tdata,
  output logic [1:0]          out_tuser
);

  localparam int PW = bfha_pkg::PTR_W;
  localparam int AW = bfha_pkg::ADDR_W;
  localparam int SW = bfha_pkg::SUM_W;

  logic                       cmd_r, null_r;
  logic [PW-1:0]              req_r, off_r;
  logic [PW-1:0]              head_r, cur_r, prv_r, prv_sz_r, cur_sz_r, cur_next_r;
  logic [PW-1:0]              best_r, best_prv_r, best_sz_r, best_next_r;
  logic [PW-1:0]              nb_sz_r, nb_next_r;
  logic [bfha_pkg::STEP_W-1:0] steps_r;
  bfha_pkg::status_t          res_st_r;
  logic [PW-1:0]              res_off_r, res_gr_r;
  logic                       out_valid_r;
  bfha_pkg::status_t          out_st_r;
  logic [PW-1:0]              out_off_r, out_gr_r;

  logic          sz_we, nx_we;
  logic [AW-1:0] sz_wa, nx_wa, rd_a;
  logic [PW-1:0] sz_wd, nx_wd, sz_rd, nx_rd;

  logic [PW-1:0] blk, repl;
  logic [SW-1:0] tail_s, req_hdr, blk_end, prv_end;
  logic          split, take, f_cond, m1, m2;
  logic [PW-1:0] nb_sz, nb_next, prv_merged;

  bfha_ram #(.WIDTH(PW), .DEPTH(bfha_pkg::HEAP_BYTES)) u_size_ram (
    .clk(clk), .wr_en(sz_we), .wr_addr(sz_wa), .wr_data(sz_wd),
    .rd_addr(rd_a), .rd_data(sz_rd)
  );

  bfha_ram #(.WIDTH(PW), .DEPTH(bfha_pkg::HEAP_BYTES)) u_next_ram (
    .clk(clk), .wr_en(nx_we), .wr_addr(nx_wa), .wr_data(nx_wd),
    .rd_addr(rd_a), .rd_data(nx_rd)
  );

  assign blk     = off_r - bfha_pkg::HDR_P;
  assign req_hdr = SW'(req_r) + bfha_pkg::HDR_S;
  assign tail_s  = SW'(best_r) + req_hdr;
  assign split   = (SW'(best_sz_r) > req_hdr) && (tail_s < SW'(bfha_pkg::HEAP_BYTES));
  assign repl    = split ? PW'(tail_s) : best_next_r;
  assign take    = (sz_rd >= req_r) && (!bfha_pkg::link_ok(best_r) || sz_rd < best_sz_r);
  assign f_cond  = (cur_r < blk) && (steps_r < bfha_pkg::MAX_STEPS);

  // Merge with the following block uses the block's own size read in the previous cycle.
  assign blk_end = SW'(blk) + bfha_pkg::HDR_S + SW'(sz_rd);
  assign m1      = bfha_pkg::link_ok(cur_r) && (blk_end == SW'(cur_r));
  assign nb_sz   = m1 ? PW'(SW'(sz_rd) + bfha_pkg::HDR_S + SW'(cur_sz_r)) : sz_rd;
  assign nb_next = m1 ? cur_next_r : cur_r;
  assign prv_end = SW'(prv_r) + bfha_pkg::HDR_S + SW'(prv_sz_r);
  assign m2      = bfha_pkg::link_ok(prv_r) && (prv_end == SW'(blk));
  assign prv_merged = PW'(SW'(prv_sz_r) + bfha_pkg::HDR_S + SW'(nb_sz_r));

  always_comb begin
    sz_we = 1'b0;
    nx_we = 1'b0;
    sz_wa = '0;
    nx_wa = '0;
    sz_wd = '0;
    nx_wd = '0;
    rd_a  = nx_rd[AW-1:0];
    case (cmd.op)
      bfha_pkg::OP_INIT: begin
        sz_we = 1'b1;
        nx_we = 1'b1;
        sz_wd = bfha_pkg::INIT_SIZE;
        nx_wd = bfha_pkg::NULL_PTR;
      end
      bfha_pkg::OP_A_START, bfha_pkg::OP_F_START: begin
        rd_a = head_r[AW-1:0];
      end
      bfha_pkg::OP_F_BLKRD: begin
        rd_a = blk[AW-1:0];
      end
      bfha_pkg::OP_A_W1: begin
        sz_we = split;
        nx_we = split;
        sz_wa = tail_s[AW-1:0];
        nx_wa = tail_s[AW-1:0];
        sz_wd = PW'(SW'(best_sz_r) - req_hdr);
        nx_wd = best_next_r;
      end
      bfha_pkg::OP_A_W2: begin
        sz_we = split;
        sz_wa = best_r[AW-1:0];
        sz_wd = req_r;
        nx_we = bfha_pkg::link_ok(best_prv_r);
        nx_wa = best_prv_r[AW-1:0];
        nx_wd = repl;
      end
      bfha_pkg::OP_A_W3: begin
        nx_we = 1'b1;
        nx_wa = best_r[AW-1:0];
        nx_wd = bfha_pkg::NULL_PTR;
      end
      bfha_pkg::OP_F_W1: begin
        sz_we = 1'b1;
        nx_we = 1'b1;
        sz_wa = blk[AW-1:0];
        nx_wa = blk[AW-1:0];
        sz_wd = nb_sz;
        nx_wd = nb_next;
      end
      bfha_pkg::OP_F_W2: begin
        sz_we = m2;
        sz_wa = prv_r[AW-1:0];
        sz_wd = prv_merged;
        nx_we = bfha_pkg::link_ok(prv_r);
        nx_wa = prv_r[AW-1:0];
        nx_wd = m2 ? nb_next_r : blk;
      end
      default: begin
        rd_a = nx_rd[AW-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == bfha_pkg::OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        bfha_pkg::OP_INIT: head_r <= '0;
        bfha_pkg::OP_A_W2: begin
          if (!bfha_pkg::link_ok(best_prv_r)) begin
            head_r <= repl;
          end
        end
        bfha_pkg::OP_F_W2: begin
          if (!bfha_pkg::link_ok(prv_r)) begin
            head_r <= blk;
          end
        end
        default: head_r <= head_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_ready && in_tvalid) begin
      cmd_r  <= in_tuser[0];
      null_r <= in_tuser[1];
      req_r  <= in_tdata[10:0];
      off_r  <= in_tdata[21:11];
    end
    case (cmd.op)
      bfha_pkg::OP_DECODE: begin
        res_st_r  <= null_r ? bfha_pkg::ST_NULL : bfha_pkg::ST_FREED;
        res_off_r <= '0;
        res_gr_r  <= '0;
      end
      bfha_pkg::OP_A_START, bfha_pkg::OP_F_START: begin
        cur_r     <= head_r;
        prv_r     <= bfha_pkg::NULL_PTR;
        best_r    <= bfha_pkg::NULL_PTR;
        steps_r   <= '0;
        res_st_r  <= bfha_pkg::ST_FREED;
        res_off_r <= '0;
        res_gr_r  <= '0;
      end
      bfha_pkg::OP_A_STEP: begin
        if (take) begin
          best_r      <= cur_r;
          best_prv_r  <= prv_r;
          best_sz_r   <= sz_rd;
          best_next_r <= nx_rd;
        end
        prv_r   <= cur_r;
        cur_r   <= nx_rd;
        steps_r <= steps_r + 1'b1;
      end
      bfha_pkg::OP_F_STEP: begin
        if (f_cond) begin
          prv_r    <= cur_r;
          prv_sz_r <= sz_rd;
          cur_r    <= nx_rd;
          steps_r  <= steps_r + 1'b1;
        end else begin
          cur_sz_r   <= sz_rd;
          cur_next_r <= nx_rd;
        end
      end
      bfha_pkg::OP_A_W1: begin
        res_st_r <= bfha_pkg::ST_NOMEM;
      end
      bfha_pkg::OP_A_W3: begin
        res_st_r  <= bfha_pkg::ST_ALLOC;
        res_off_r <= best_r + bfha_pkg::HDR_P;
        res_gr_r  <= split ? req_r : best_sz_r;
      end
      bfha_pkg::OP_F_W1: begin
        nb_sz_r   <= nb_sz;
        nb_next_r <= nb_next;
      end
      bfha_pkg::OP_EMIT: begin
        out_st_r  <= res_st_r;
        out_off_r <= res_off_r;
        out_gr_r  <= res_gr_r;
      end
      default: begin
        steps_r <= steps_r;
      end
    endcase
  end

  assign sts.is_alloc = !cmd_r;
  assign sts.is_null  = null_r;
  assign sts.bad_off  = (off_r < bfha_pkg::HDR_P) || !bfha_pkg::link_ok(blk);
  assign sts.head_ok  = bfha_pkg::link_ok(head_r);
  assign sts.a_more   = bfha_pkg::link_ok(nx_rd) && ((steps_r + 1'b1) < bfha_pkg::MAX_STEPS);
  assign sts.f_stay   = f_cond && bfha_pkg::link_ok(nx_rd);
  assign sts.best_ok  = bfha_pkg::link_ok(best_r);
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {2'b00, out_gr_r, out_off_r};

endmodule

// ----- hdl/bfha_checker.sv -----
// Port-level checker for the allocator core, bound to the top level.
module bfha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != bfha_pkg::ST_ALLOC |-> out_tdata == 24'd0)
    else $error("non-allocating result carries data");

  a_alloc_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == bfha_pkg::ST_ALLOC |->
      out_tdata[10:0] >= bfha_pkg::HDR_P && out_tdata[23:22] == 2'b00)
    else $error("allocated offset inside a header");

  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("block ready straight after reset");

endmodule

bind best_fit_heap_allocator_core bfha_checker u_bfha_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata), .out_tuser(out_tuser)
);

// ----- dv/tb_best_fit_heap_allocator_core.sv -----
// Self-checking testbench of the best-fit heap allocator: directed and random traffic with a predictor.
module tb_best_fit_heap_allocator_core;

  localparam int   HEAP_BYTES   = bfha_pkg::HEAP_BYTES;
  localparam int   HEADER_BYTES = bfha_pkg::HEADER_BYTES;
  localparam int   MAX_NODES    = bfha_pkg::MAX_NODES;
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;
  localparam int   STALL_LIMIT = 3000;

  class heap_scoreboard;
    int unsigned head;
    int unsigned blk_size [HEAP_BYTES];
    int unsigned blk_next [HEAP_BYTES];
    int unsigned live_q [$];
    int unsigned freed_q [$];
    logic [1:0]  want_status [$];
    logic [10:0] want_offset [$];
    logic [10:0] want_size [$];
    bit          failed;

    function new();
      head = 0;
      blk_size[0] = HEAP_BYTES - HEADER_BYTES;
      blk_next[0] = HEAP_BYTES;
      failed = 0;
    endfunction

    function automatic void expect_result(logic [1:0] st, int unsigned off, int unsigned sz);
      want_status.push_back(st);
      want_offset.push_back(off[10:0]);
      want_size.push_back(sz[10:0]);
    endfunction

    function automatic void best_fit(int unsigned req);
      int unsigned cur, prv, best, best_prv, steps, bsz, tail, repl;
      cur = head; prv = HEAP_BYTES; best = HEAP_BYTES; best_prv = HEAP_BYTES; steps = 0;
      while (cur < HEAP_BYTES && steps < MAX_NODES) begin
        if (blk_size[cur] >= req && (best >= HEAP_BYTES || blk_size[cur] < blk_size[best])) begin
          best = cur;
          best_prv = prv;
        end
        prv = cur;
        cur = blk_next[cur];
        steps++;
      end
      if (best >= HEAP_BYTES) begin
        expect_result(bfha_pkg::ST_NOMEM, 0, 0);
        return;
      end
      bsz = blk_size[best];
      tail = best + HEADER_BYTES + req;
      if (bsz <= req + HEADER_BYTES || tail >= HEAP_BYTES) begin
        repl = blk_next[best];
      end else begin
        blk_size[tail] = bsz - req - HEADER_BYTES;
        blk_next[tail] = blk_next[best];
        blk_size[best] = req;
        repl = tail;
      end
      if (best_prv < HEAP_BYTES) blk_next[best_prv] = repl;
      else head = repl;
      blk_next[best] = HEAP_BYTES;
      live_q.push_back(best + HEADER_BYTES);
      expect_result(bfha_pkg::ST_ALLOC, best + HEADER_BYTES, blk_size[best]);
    endfunction

    function automatic void release_block(int unsigned off);
      int unsigned blk, cur, prv, steps;
      prv = HEAP_BYTES; steps = 0;
      if (off < HEADER_BYTES) return;
      blk = off - HEADER_BYTES;
      if (blk >= HEAP_BYTES) return;
      cur = head;
      while (cur < HEAP_BYTES && cur < blk && steps < MAX_NODES) begin
        prv = cur;
        cur = blk_next[cur];
        steps++;
      end
      if (cur >= HEAP_BYTES) cur = HEAP_BYTES;
      blk_next[blk] = cur;
      if (prv < HEAP_BYTES) blk_next[prv] = blk;
      else head = blk;
      if (cur < HEAP_BYTES && blk + HEADER_BYTES + blk_size[blk] == cur) begin
        blk_size[blk] += HEADER_BYTES + blk_size[cur];
        blk_next[blk] = blk_next[cur];
      end
      if (prv < HEAP_BYTES && prv + HEADER_BYTES + blk_size[prv] == blk) begin
        blk_size[prv] += HEADER_BYTES + blk_size[blk];
        blk_next[prv] = blk_next[blk];
      end
    endfunction

    // Called on every accepted input transfer.
    function automatic void note_request(logic cmd, logic [10:0] req, logic [10:0] off,
                                         logic is_null);
      if (cmd == CMD_ALLOC) begin
        best_fit(req);
      end else if (is_null) begin
        expect_result(bfha_pkg::ST_NULL, 0, 0);
      end else begin
        release_block(off);
        expect_result(bfha_pkg::ST_FREED, 0, 0);
      end
    endfunction

    function automatic void check_result(logic [1:0] st, logic [10:0] off, logic [10:0] sz);
      logic [1:0]  e_st;
      logic [10:0] e_off, e_sz;
      if (want_status.size() == 0) begin
        $display("%0t: unexpected result status %0d offset %0d size %0d", $time, st, off, sz);
        failed = 1;
        return;
      end
      e_st = want_status.pop_front();
      e_off = want_offset.pop_front();
      e_sz = want_size.pop_front();
      if (st !== e_st) begin
        $display("%0t: status expected %0d actual %0d", $time, e_st, st);
        failed = 1;
      end
      if (off !== e_off) begin
        $display("%0t: data_offset expected %0d actual %0d", $time, e_off, off);
        failed = 1;
      end
      if (sz !== e_sz) begin
        $display("%0t: granted_size expected %0d actual %0d", $time, e_sz, sz);
        failed = 1;
      end
    endfunction

    function automatic int pending();
      return want_status.size();
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;

  heap_scoreboard sb = new();
  bit  calm = 0;
  int  idle_cycles = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  best_fit_heap_allocator_core dut (.*);

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_request(in_tuser[0], in_tdata[10:0], in_tdata[21:11], in_tuser[1]);
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, out_tdata[10:0], out_tdata[21:11]);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    if (!calm && $urandom_range(99) < 15) out_tready <= 0;
    else out_tready <= 1;
  end

  task automatic push_item(logic cmd, logic [10:0] req, logic [10:0] off, logic is_null);
    if (!calm && $urandom_range(99) < 15) begin
      in_tvalid = 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tdata = {2'b00, off, req};
    in_tuser = {is_null, cmd};
    in_tvalid = 1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic do_alloc(int unsigned req);
    push_item(CMD_ALLOC, req[10:0], 11'($urandom_range(2047)), 1'($urandom_range(1)));
  endtask

  task automatic do_free(int unsigned off);
    push_item(CMD_FREE, 11'($urandom_range(2047)), off[10:0], 1'b0);
  endtask

  task automatic free_live(int idx);
    int unsigned off;
    off = sb.live_q[idx];
    sb.live_q.delete(idx);
    sb.freed_q.push_back(off);
    do_free(off);
  endtask

  initial begin
    int unsigned r, req;
    repeat (2) @(negedge clk);
    rst_n = 1;

    // Directed opening: extremes, ties, both merges, null and bad frees.
    do_alloc(1024);
    do_alloc(1008);
    free_live(0);
    do_alloc(0);
    do_alloc(32);
    do_alloc(32);
    do_alloc(32);
    do_alloc(1);
    free_live(1);
    free_live(2);
    do_alloc(32);
    do_alloc(20);
    push_item(CMD_FREE, 11'd2047, 11'd2047, 1'b1);
    push_item(CMD_FREE, 11'd0, 11'd0, 1'b0);
    push_item(CMD_FREE, 11'd0, 11'd15, 1'b0);
    while (sb.live_q.size() > 0) free_live(0);
    do_alloc(1008);
    free_live(0);

    for (int i = 0; i < 1300; i++) begin
      calm = (i >= 500 && i < 750);
      r = $urandom_range(99);
      if (r < 3) begin
        push_item(CMD_FREE, 11'($urandom_range(2047)), 11'($urandom_range(2047)), 1'b1);
      end else if (r < 5) begin
        do_free($urandom_range(HEADER_BYTES - 1));
      end else if (r < 6 && sb.freed_q.size() > 0) begin
        // Stale free of a block that has already been released.
        do_free(sb.freed_q[$urandom_range(sb.freed_q.size() - 1)]);
      end else if (r < 50 && sb.live_q.size() > 0) begin
        free_live($urandom_range(sb.live_q.size() - 1));
      end else begin
        if ($urandom_range(19) == 0) req = $urandom_range(1024);
        else req = $urandom_range(120);
        do_alloc(req);
      end
    end
    in_tvalid = 0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (!sb.failed && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
